>>> src/cofp_pkg.sv
// ----------------------------------------------------------------------------
// cofp_pkg
// shared types and constants for the gas sensor frame parser
// ----------------------------------------------------------------------------
package cofp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned ConcW   = 13;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 3;

  localparam logic [ByteW-1:0] SYNC_BYTE     = 8'hFF;
  localparam logic [ByteW-1:0] TYPE_QUERY    = 8'h86;
  localparam logic [ByteW-1:0] TYPE_ACTIVE   = 8'h04;
  localparam logic [ByteW-1:0] VALUE_MASK_HI = 8'h1F;
  localparam logic [ByteW-1:0] FAULT_BIT     = 8'h80;

  // register word index
  localparam logic REG_QUERY_MODE = 1'b0;

  // parser positions
  localparam logic [PosW-1:0] POS_HUNT       = 4'd0;
  localparam logic [PosW-1:0] POS_TYPE       = 4'd1;
  localparam logic [PosW-1:0] POS_DATA_FIRST = 4'd2;
  localparam logic [PosW-1:0] POS_DATA_LAST  = 4'd7;
  localparam logic [PosW-1:0] POS_CHK        = 4'd8;
  localparam logic [PosW-1:0] POS_HI_QUERY   = 4'd2;
  localparam logic [PosW-1:0] POS_HI_ACTIVE  = 4'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic query_mode;
    logic restart;
  } cfg_ctl_t;

endpackage

>>> src/cofp_regs.sv
// ----------------------------------------------------------------------------
// cofp_regs
// apb register file holding the frame type mode
// ----------------------------------------------------------------------------
module cofp_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cofp_pkg::AddrW-1:0]  paddr,
  input  logic [cofp_pkg::DataW-1:0]  pwdata,
  output logic [cofp_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output cofp_pkg::cfg_ctl_t          ctl
);

  logic query_mode_r;
  logic query_mode_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == cofp_pkg::REG_QUERY_MODE);

  assign query_mode_nxt = wr_en ? pwdata[0] : query_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_mode_r <= 1'b0;
    end else begin
      query_mode_r <= query_mode_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cofp_pkg::REG_QUERY_MODE) begin
      prdata[0] = query_mode_r;
    end
  end

  assign ctl.query_mode = query_mode_r;
  assign ctl.restart    = wr_en && (pwdata[0] != query_mode_r);

endmodule

>>> src/cofp_parser.sv
// ----------------------------------------------------------------------------
// cofp_parser
// frame position tracking, checksum and result register
// ----------------------------------------------------------------------------
module cofp_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cofp_pkg::cfg_ctl_t            ctl,
  input  logic                          byte_vld,
  input  logic [cofp_pkg::ByteW-1:0]    byte_in,
  output logic                          stall,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cofp_pkg::ConcW-1:0]    out_co_tenths_ppm,
  output logic                          out_fault_flag,
  output logic                          out_frame_status
);

  logic [cofp_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [cofp_pkg::ByteW-1:0] sum_r, sum_nxt;
  logic [cofp_pkg::ByteW-1:0] hi_r, hi_nxt;
  logic [cofp_pkg::ByteW-1:0] lo_r, lo_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [cofp_pkg::ConcW-1:0] co_r, co_nxt;
  logic                       fault_r, fault_nxt;
  logic                       status_r, status_nxt;
  logic [cofp_pkg::PosW-1:0]  hi_pos;
  logic [cofp_pkg::ByteW-1:0] want_type;
  logic [cofp_pkg::ByteW-1:0] chk_sum;
  logic                       emit;

  assign stall     = (pos_r == cofp_pkg::POS_CHK) && out_valid_r && !out_ready;
  assign hi_pos    = ctl.query_mode ? cofp_pkg::POS_HI_QUERY : cofp_pkg::POS_HI_ACTIVE;
  assign want_type = ctl.query_mode ? cofp_pkg::TYPE_QUERY : cofp_pkg::TYPE_ACTIVE;
  assign chk_sum   = sum_r + byte_in;

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    emit    = 1'b0;
    if (byte_vld) begin
      unique case (pos_r) inside
        cofp_pkg::POS_TYPE: begin
          if (byte_in == want_type) begin
            sum_nxt = byte_in;
            pos_nxt = cofp_pkg::POS_DATA_FIRST;
          end else begin
            pos_nxt = cofp_pkg::POS_HUNT;
          end
        end
        [cofp_pkg::POS_DATA_FIRST:cofp_pkg::POS_DATA_LAST]: begin
          sum_nxt = chk_sum;
          if (pos_r == hi_pos) begin
            hi_nxt = byte_in;
          end else if (pos_r == hi_pos + 4'd1) begin
            lo_nxt = byte_in;
          end
          pos_nxt = pos_r + 4'd1;
        end
        cofp_pkg::POS_CHK: begin
          pos_nxt = cofp_pkg::POS_HUNT;
          emit    = 1'b1;
        end
        default: begin
          if (byte_in == cofp_pkg::SYNC_BYTE) begin
            pos_nxt = cofp_pkg::POS_TYPE;
            sum_nxt = '0;
          end else begin
            pos_nxt = cofp_pkg::POS_HUNT;
          end
        end
      endcase
    end
    if (ctl.restart) begin
      pos_nxt = cofp_pkg::POS_HUNT;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    co_nxt        = co_r;
    fault_nxt     = fault_r;
    status_nxt    = status_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (chk_sum == '0) begin
        co_nxt     = {hi_r[4:0] & cofp_pkg::VALUE_MASK_HI[4:0], lo_r};
        fault_nxt  = (hi_r & cofp_pkg::FAULT_BIT) != '0;
        status_nxt = cofp_pkg::STATUS_OK;
      end else begin
        co_nxt     = '0;
        fault_nxt  = 1'b0;
        status_nxt = cofp_pkg::STATUS_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= cofp_pkg::POS_HUNT;
      sum_r       <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    co_r     <= co_nxt;
    fault_r  <= fault_nxt;
    status_r <= status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_co_tenths_ppm = co_r;
  assign out_fault_flag    = fault_r;
  assign out_frame_status  = status_r;

endmodule

>>> src/co_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// co_sensor_frame_parser
// nine byte uart gas sensor frame parser with apb mode register
// result path: the checksum beat passes the input register, then the result
//   register, which drives out_valid
// throughput: one rx beat per cycle; the checksum beat holds in the input
//   register only while a previous result is still waiting on out_ready
// reset: synchronous active low, parser returns to start byte hunt, mode 0
// ----------------------------------------------------------------------------
module co_sensor_frame_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cofp_pkg::ByteW-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cofp_pkg::ConcW-1:0]  out_co_tenths_ppm,
  output logic                        out_fault_flag,
  output logic                        out_frame_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cofp_pkg::AddrW-1:0]  paddr,
  input  logic [cofp_pkg::DataW-1:0]  pwdata,
  output logic [cofp_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  cofp_pkg::cfg_ctl_t         ctl;
  logic                       s1_valid_r, s1_valid_nxt;
  logic [cofp_pkg::ByteW-1:0] s1_byte_r, s1_byte_nxt;
  logic                       stall;
  logic                       s1_adv;

  cofp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  // input register
  assign s1_adv   = s1_valid_r && !stall;
  assign in_ready = !s1_valid_r || !stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r && stall;
    s1_byte_nxt  = s1_byte_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
  end

  cofp_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .byte_vld          (s1_adv),
    .byte_in           (s1_byte_r),
    .stall             (stall),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_co_tenths_ppm (out_co_tenths_ppm),
    .out_fault_flag    (out_fault_flag),
    .out_frame_status  (out_frame_status)
  );

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == cofp_pkg::STATUS_BAD)
      |-> (out_co_tenths_ppm == '0) && !out_fault_flag)
    else $error("checksum error result carries data");

  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid && !out_ready)
    else $error("input stalled without a pending result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && stall |=> s1_valid_r && $stable(s1_byte_r))
    else $error("held beat lost from input register");

endmodule
